### sv/lpht_pkg.sv
// lpht_pkg: shared widths, operation and status codes, memory word and command types
// for the linear probing hash table; no dependencies
package lpht_pkg;

    localparam int OP_W           = 2;
    localparam int KEY_W          = 31;
    localparam int ST_W           = 2;
    localparam int SLOT_W         = 3;
    localparam int TABLE_SIZE_DEF = 8;
    localparam int ADDR_MAX_W     = 10;
    localparam int DIGIT_BITS     = 8;
    localparam int KEY_DIGITS     = 4;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef struct packed {
        logic             vld;
        logic [KEY_W-1:0] key;
    } t_entry;

    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_MAX_W-1:0] rd_addr;
        logic                  wr_en;
        logic [ADDR_MAX_W-1:0] wr_addr;
        t_entry                wr_data;
    } t_mem_cmd;

endpackage

### sv/lpht_if.sv
// lpht_req_if and lpht_rsp_if: valid/ready channels for request and result items
// depends on lpht_pkg
interface lpht_req_if;
    import lpht_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  req_type;
    logic [KEY_W-1:0] key;

    modport source (output valid, output req_type, output key, input ready);
    modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface lpht_rsp_if;
    import lpht_pkg::*;

    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

### sv/linear_probe_hash_table_unit.sv
// linear_probe_hash_table_unit: top level of the linear probing hash table
// depends on lpht_pkg, lpht_if, lpht_mod_unit and lpht_table
//
// usage:
//   i_req carries one request item (req_type insert/delete/search, 31-bit key),
//   o_rsp returns one result item (status, slot) per request, in order.
//   the block handles one request at a time: the key is reduced modulo
//   TABLE_SIZE one 8-bit digit per cycle, 4 digits in all, then the slot memory
//   is read one slot per cycle along the probe sequence until a hit or until
//   all TABLE_SIZE slots are checked.
//   a new request is taken only in the idle state, once the previous item has
//   left the finish state. the single memory read port sets the probe rate.
//   after reset a clearing pass writes every slot empty, with i_req.ready low.
//   the result sits in an output register; while the receiver stalls, the
//   next request is still accepted and processed, and its result waits in the
//   finish state until the output register is free.
module linear_probe_hash_table_unit #(
    parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpht_req_if.sink   i_req,
    lpht_rsp_if.source o_rsp
);
    import lpht_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);
    localparam logic [CW-1:0] N_CNT    = CW'(TABLE_SIZE);
    localparam logic [CW-1:0] N_LAST   = CW'(TABLE_SIZE - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_MOD   = 5'b00100,
        S_PROBE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state            r_state,      n_state;
    logic [OP_W-1:0]   r_op,         n_op;
    logic [KEY_W-1:0]  r_key,        n_key;
    logic [IW-1:0]     r_idx,        n_idx;
    logic [CW-1:0]     r_issued,     n_issued;
    logic              r_chk_vld,    n_chk_vld;
    logic [IW-1:0]     r_chk_idx,    n_chk_idx;
    logic              r_chk_last,   n_chk_last;
    logic              r_hit,        n_hit;
    logic [IW-1:0]     r_hit_idx,    n_hit_idx;
    logic [IW-1:0]     r_clr_addr,   n_clr_addr;
    logic              r_out_vld,    n_out_vld;
    t_status           r_out_status, n_out_status;
    logic [SLOT_W-1:0] r_out_slot,   n_out_slot;

    t_mem_cmd      mem_cmd;
    t_entry        mem_rdata;
    logic          in_fire;
    logic          out_free;
    logic          probe_hit;
    logic          mod_done;
    logic [IW-1:0] mod_rem;
    t_status       fin_status;

    lpht_mod_unit #(.TABLE_SIZE(TABLE_SIZE)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire),
        .i_key   (i_req.key),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    lpht_table #(.TABLE_SIZE(TABLE_SIZE)) u_table (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .o_rdata (mem_rdata)
    );

    assign i_req.ready  = (r_state == S_IDLE);
    assign in_fire      = i_req.valid && i_req.ready;
    assign out_free     = !r_out_vld || o_rsp.ready;
    assign o_rsp.valid  = r_out_vld;
    assign o_rsp.status = r_out_status;
    assign o_rsp.slot   = r_out_slot;

    assign probe_hit = r_chk_vld && ((r_op == OP_INSERT) ? !mem_rdata.vld
                       : (mem_rdata.vld && (mem_rdata.key == r_key)));

    always_comb begin
        case (r_op) inside
            OP_INSERT:            fin_status = r_hit ? ST_OK : ST_FULL;
            OP_DELETE, OP_SEARCH: fin_status = r_hit ? ST_OK : ST_MISSING;
            default:              fin_status = ST_MISSING;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_idx        = r_idx;
        n_issued     = r_issued;
        n_chk_vld    = r_chk_vld;
        n_chk_idx    = r_chk_idx;
        n_chk_last   = r_chk_last;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_clr_addr   = r_clr_addr;
        n_out_vld    = r_out_vld;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        mem_cmd      = '0;

        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = ADDR_MAX_W'(r_clr_addr);
                n_clr_addr      = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_op    = i_req.req_type;
                    n_key   = i_req.key;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_idx     = mod_rem;
                    n_issued  = '0;
                    n_chk_vld = 1'b0;
                    n_hit     = 1'b0;
                    n_state   = S_PROBE;
                end
            end
            S_PROBE: begin
                n_chk_vld = 1'b0;
                if (r_issued != N_CNT) begin
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = ADDR_MAX_W'(r_idx);
                    n_idx           = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                    n_issued        = r_issued + 1'b1;
                    n_chk_vld       = 1'b1;
                    n_chk_idx       = r_idx;
                    n_chk_last      = (r_issued == N_LAST);
                end
                if (probe_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_chk_idx;
                    n_state   = S_DONE;
                end else if (r_chk_vld && r_chk_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = fin_status;
                    n_out_slot   = (fin_status == ST_OK) ? SLOT_W'(r_hit_idx) : '0;
                    if (r_hit && (r_op == OP_INSERT || r_op == OP_DELETE)) begin
                        mem_cmd.wr_en       = 1'b1;
                        mem_cmd.wr_addr     = ADDR_MAX_W'(r_hit_idx);
                        mem_cmd.wr_data.vld = (r_op == OP_INSERT);
                        mem_cmd.wr_data.key = r_key;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_chk_vld  <= 1'b0;
            r_issued   <= '0;
            r_hit      <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_chk_vld  <= n_chk_vld;
            r_issued   <= n_issued;
            r_hit      <= n_hit;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_chk_idx    <= n_chk_idx;
        r_chk_last   <= n_chk_last;
        r_hit_idx    <= n_hit_idx;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
    end

`ifndef NO_ASSERTIONS
    a_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_cmd.wr_en |-> (r_state == S_DONE || r_state == S_CLEAR))
        else $error("slot memory written outside finish or clearing");
    a_rd_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_cmd.rd_en && mem_cmd.wr_en))
        else $error("slot memory read and written in the same cycle");
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_issued <= N_CNT))
        else $error("more probes than slots");
    a_miss_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status != ST_OK) |-> (r_out_slot == '0))
        else $error("nonzero slot on failed request");
    a_mod_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (r_state == S_MOD))
        else $error("modulo result outside reduction state");
`endif
endmodule

### sv/lpht_mod_unit.sv
// lpht_mod_unit: iterative key modulo table size, one 8-bit digit per cycle
// depends on lpht_pkg
module lpht_mod_unit #(
    parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [lpht_pkg::KEY_W-1:0]       i_key,
    output logic                             o_done,
    output logic [$clog2(TABLE_SIZE)-1:0]    o_rem
);
    import lpht_pkg::*;

    localparam int IW    = $clog2(TABLE_SIZE);
    localparam int TW    = IW + DIGIT_BITS;
    localparam int PAD_W = KEY_DIGITS * DIGIT_BITS;
    localparam int CNT_W = $clog2(KEY_DIGITS);
    localparam logic [TW-1:0]    N_W      = TW'(TABLE_SIZE);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(KEY_DIGITS - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [PAD_W-1:0] r_sh;
    logic [IW-1:0]    r_rem;
    logic [IW-1:0]    n_rem;
    logic [TW-1:0]    part;

    // restoring reduction of {remainder, digit}
    always_comb begin
        part = {r_rem, r_sh[PAD_W-1 -: DIGIT_BITS]};
        for (int j = DIGIT_BITS - 1; j >= 0; j--) begin
            if (part >= (N_W << j)) begin
                part = part - (N_W << j);
            end
        end
        n_rem = part[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= PAD_W'(i_key);
            r_rem <= '0;
        end else if (r_busy) begin
            r_sh  <= r_sh << DIGIT_BITS;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("modulo start while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done held longer than one cycle");
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (32'(o_rem) < 32'(TABLE_SIZE)))
        else $error("remainder out of range");
`endif
endmodule

### sv/lpht_table.sv
// lpht_table: slot memory holding valid bit and key, one write and one read port,
// registered read data; depends on lpht_pkg
module lpht_table #(
    parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
    input  logic               i_clk,
    input  lpht_pkg::t_mem_cmd i_cmd,
    output lpht_pkg::t_entry   o_rdata
);
    import lpht_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);

    t_entry r_mem [TABLE_SIZE];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr[IW-1:0]] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_cmd.rd_addr[IW-1:0]];
        end
    end

    assign o_rdata = r_rdata;
endmodule
